// File: rtl/expression_char_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Expression character tokenizer assertion macros
// Concurrent assertion helpers shared by the tokenizer RTL; compiled out
// when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_CHAR_TOKENIZER_MACROS_SVH
`define EXPRESSION_CHAR_TOKENIZER_MACROS_SVH

`ifndef NO_ASSERTIONS

// implication checked on every clock edge outside reset
`define ECT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// invariant checked on every clock edge outside reset
`define ECT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`else

`define ECT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ECT_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/ect_pkg.sv
// ----------------------------------------------------------------------------
// Expression character tokenizer package
// Widths, character and token codes, operator tables and shared types.
// ----------------------------------------------------------------------------
package ect_pkg;

  // field widths
  localparam int unsigned CH_W     = 8;
  localparam int unsigned KIND_W   = 4;
  localparam int unsigned SUB_W    = 3;
  localparam int unsigned NEST_W   = 8;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned HELD_W   = 4;

  // deepest bracket nesting accepted
  localparam logic [NEST_W-1:0] NEST_LIMIT = 8'd255;
  // longest name length before saturation
  localparam logic [POS_W-1:0]  LEN_SAT    = 16'hFFFF;

  // result queue
  localparam int unsigned QDEPTH   = 8;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = QPTR_W + 1;
  localparam int unsigned PUSH_MAX = 3;
  localparam int unsigned PCNT_W   = 2;
  localparam int unsigned PIDX_W   = 2;

  // characters of interest
  localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CH_W-1:0] CH_AMP    = 8'h26;
  localparam logic [CH_W-1:0] CH_BAR    = 8'h7C;
  localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CH_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CH_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CH_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CH_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

  // held operator codes
  localparam logic [HELD_W-1:0] HELD_NONE  = 4'd0;
  localparam logic [HELD_W-1:0] HELD_GT    = 4'd1;
  localparam logic [HELD_W-1:0] HELD_LT    = 4'd2;
  localparam logic [HELD_W-1:0] HELD_BANG  = 4'd3;
  localparam logic [HELD_W-1:0] HELD_PLUS  = 4'd4;
  localparam logic [HELD_W-1:0] HELD_MINUS = 4'd5;
  localparam logic [HELD_W-1:0] HELD_STAR  = 4'd6;
  localparam logic [HELD_W-1:0] HELD_EQ    = 4'd7;
  localparam logic [HELD_W-1:0] HELD_AMP   = 4'd8;
  localparam logic [HELD_W-1:0] HELD_BAR   = 4'd9;
  localparam logic [HELD_W-1:0] HELD_COMMA = 4'd10;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_NAME   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_LBRACK = 4'd1;
  localparam logic [KIND_W-1:0] KIND_RBRACK = 4'd2;
  localparam logic [KIND_W-1:0] KIND_AND    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_OR     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_CMP    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_OP     = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 4'd8;
  localparam logic [KIND_W-1:0] KIND_END    = 4'd9;

  // sub codes
  localparam logic [SUB_W-1:0] SUB_NONE = 3'd0;
  localparam logic [SUB_W-1:0] CMP_GT   = 3'd0;
  localparam logic [SUB_W-1:0] CMP_GE   = 3'd1;
  localparam logic [SUB_W-1:0] CMP_LT   = 3'd2;
  localparam logic [SUB_W-1:0] CMP_LE   = 3'd3;
  localparam logic [SUB_W-1:0] CMP_EQ   = 3'd4;
  localparam logic [SUB_W-1:0] CMP_NE   = 3'd5;
  localparam logic [SUB_W-1:0] OP_ADD   = 3'd0;
  localparam logic [SUB_W-1:0] OP_SUB   = 3'd1;
  localparam logic [SUB_W-1:0] OP_MUL   = 3'd2;
  localparam logic [SUB_W-1:0] OP_NOT   = 3'd3;
  localparam logic [SUB_W-1:0] ASG_SET  = 3'd0;
  localparam logic [SUB_W-1:0] ASG_ADD  = 3'd1;
  localparam logic [SUB_W-1:0] ASG_SUB  = 3'd2;
  localparam logic [SUB_W-1:0] ASG_MUL  = 3'd3;

  // end status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_BRACKET   = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNEXP_END = 3'd4;
  localparam logic [STAT_W-1:0] ST_COMMA     = 3'd5;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd6;

  // one result token
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SUB_W-1:0]  sub;
    logic [NEST_W-1:0] nest_depth;
    logic [POS_W-1:0]  span_start;
    logic [POS_W-1:0]  span_len;
    logic [STAT_W-1:0] status;
    logic              final_res;
  } tok_t;

  // tokens produced by one character, first in slot zero
  typedef struct packed {
    logic [PCNT_W-1:0]        cnt;
    tok_t [PUSH_MAX-1:0]      tok;
  } ect_push_t;

  function automatic tok_t mk_tok(logic [KIND_W-1:0] kind, logic [SUB_W-1:0] sub,
                                  logic [NEST_W-1:0] nd, logic [POS_W-1:0] ss,
                                  logic [POS_W-1:0] sl, logic [STAT_W-1:0] st,
                                  logic fin);
    tok_t t;
    t.kind       = kind;
    t.sub        = sub;
    t.nest_depth = nd;
    t.span_start = ss;
    t.span_len   = sl;
    t.status     = st;
    t.final_res  = fin;
    return t;
  endfunction

  // operator byte to held code
  function automatic logic [HELD_W-1:0] op_code(logic [CH_W-1:0] c);
    logic [HELD_W-1:0] r;
    case (c)
      CH_GT:    r = HELD_GT;
      CH_LT:    r = HELD_LT;
      CH_BANG:  r = HELD_BANG;
      CH_PLUS:  r = HELD_PLUS;
      CH_MINUS: r = HELD_MINUS;
      CH_STAR:  r = HELD_STAR;
      CH_EQ:    r = HELD_EQ;
      CH_AMP:   r = HELD_AMP;
      CH_BAR:   r = HELD_BAR;
      default:  r = HELD_NONE;
    endcase
    return r;
  endfunction

  // token for a held operator that stood alone
  function automatic tok_t single_tok(logic [HELD_W-1:0] h);
    tok_t t;
    t = '0;
    case (h)
      HELD_GT:    begin t.kind = KIND_CMP;    t.sub = CMP_GT;  end
      HELD_LT:    begin t.kind = KIND_CMP;    t.sub = CMP_LT;  end
      HELD_BANG:  begin t.kind = KIND_OP;     t.sub = OP_NOT;  end
      HELD_PLUS:  begin t.kind = KIND_OP;     t.sub = OP_ADD;  end
      HELD_MINUS: begin t.kind = KIND_OP;     t.sub = OP_SUB;  end
      HELD_STAR:  begin t.kind = KIND_OP;     t.sub = OP_MUL;  end
      HELD_EQ:    begin t.kind = KIND_ASSIGN; t.sub = ASG_SET; end
      default:    begin t.kind = KIND_NAME;   t.sub = SUB_NONE; end
    endcase
    return t;
  endfunction

  // token for a held operator that found its follower
  function automatic tok_t full_tok(logic [HELD_W-1:0] h, logic [NEST_W-1:0] depth);
    tok_t t;
    t = '0;
    case (h)
      HELD_GT:    begin t.kind = KIND_CMP;    t.sub = CMP_GE;  end
      HELD_LT:    begin t.kind = KIND_CMP;    t.sub = CMP_LE;  end
      HELD_BANG:  begin t.kind = KIND_CMP;    t.sub = CMP_NE;  end
      HELD_PLUS:  begin t.kind = KIND_ASSIGN; t.sub = ASG_ADD; end
      HELD_MINUS: begin t.kind = KIND_ASSIGN; t.sub = ASG_SUB; end
      HELD_STAR:  begin t.kind = KIND_ASSIGN; t.sub = ASG_MUL; end
      HELD_EQ:    begin t.kind = KIND_CMP;    t.sub = CMP_EQ;  end
      HELD_AMP:   begin t.kind = KIND_AND;    t.sub = SUB_NONE; end
      HELD_BAR:   begin t.kind = KIND_OR;     t.sub = SUB_NONE; end
      HELD_COMMA: begin
        t.kind       = KIND_COMMA;
        t.sub        = SUB_NONE;
        t.nest_depth = depth;
      end
      default:    begin t.kind = KIND_NAME;   t.sub = SUB_NONE; end
    endcase
    return t;
  endfunction

endpackage

// File: rtl/ect_if.sv
// ----------------------------------------------------------------------------
// Expression character tokenizer channels
// Valid/ready channels for character beats in and token beats out.
// ----------------------------------------------------------------------------
interface ect_in_if import ect_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ect_out_if import ect_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SUB_W-1:0]  sub;
  logic [NEST_W-1:0] nest_depth;
  logic [POS_W-1:0]  span_start;
  logic [POS_W-1:0]  span_len;
  logic [STAT_W-1:0] status;
  logic              final_res;

  modport source (output valid, output kind, output sub, output nest_depth,
                  output span_start, output span_len, output status,
                  output final_res, input ready);
  modport sink   (input valid, input kind, input sub, input nest_depth,
                  input span_start, input span_len, input status,
                  input final_res, output ready);
endinterface

// File: rtl/ect_core.sv
// ----------------------------------------------------------------------------
// Expression character tokenizer core
// Per-character token decision and the tokenizer state registers.
// ----------------------------------------------------------------------------
module ect_core import ect_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            beat_i,
  input  logic [CH_W-1:0] ch_i,
  input  logic            last_i,
  output ect_push_t       push_o
);

  logic [NEST_W-1:0] depth_q, depth_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic              full_q, full_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  nstart_q, nstart_d;
  logic [POS_W-1:0]  nlen_q, nlen_d;
  logic              any_q, any_d;
  logic [STAT_W-1:0] err_q, err_d;

  logic                ws;
  logic                stop;
  logic [PCNT_W-1:0]   ntok;
  tok_t [PUSH_MAX-1:0] toks;
  logic [HELD_W-1:0]   code;

  assign ws   = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));
  assign code = op_code(ch_i);

  // token decision for one character
  always_comb begin
    depth_d  = depth_q;
    held_d   = held_q;
    full_d   = full_q;
    pos_d    = pos_q;
    nstart_d = nstart_q;
    nlen_d   = nlen_q;
    any_d    = any_q;
    err_d    = err_q;
    ntok     = '0;
    toks     = '0;
    stop     = 1'b0;

    if (!ws && (err_q == ST_OK)) begin
      pos_d = pos_q + 16'd1;

      // resolve a held operator first
      if (held_q != HELD_NONE) begin
        if (full_q) begin
          toks[PIDX_W'(ntok)] = full_tok(held_q, depth_q);
          ntok   = ntok + 2'd1;
          any_d  = 1'b1;
          held_d = HELD_NONE;
          full_d = 1'b0;
        end else if ((held_q == HELD_AMP) || (held_q == HELD_BAR)) begin
          if (((held_q == HELD_AMP) && (ch_i == CH_AMP)) ||
              ((held_q == HELD_BAR) && (ch_i == CH_BAR))) begin
            full_d = 1'b1;
          end else begin
            err_d = ST_UNKNOWN;
          end
          stop = 1'b1;
        end else if (ch_i == CH_EQ) begin
          full_d = 1'b1;
          stop   = 1'b1;
        end else begin
          toks[PIDX_W'(ntok)] = single_tok(held_q);
          ntok   = ntok + 2'd1;
          any_d  = 1'b1;
          held_d = HELD_NONE;
        end
      end

      // then the character itself
      if (!stop) begin
        case (ch_i)
          CH_LPAREN: begin
            if (last_i) begin
              err_d = ST_BRACKET;
            end else if (depth_q >= NEST_LIMIT) begin
              err_d = ST_OVERFLOW;
            end else begin
              if (nlen_q != '0) begin
                toks[PIDX_W'(ntok)] = mk_tok(KIND_NAME, SUB_NONE, '0, nstart_q, nlen_q,
                                             ST_OK, 1'b0);
                ntok   = ntok + 2'd1;
                nlen_d = '0;
              end
              depth_d = depth_q + 8'd1;
              toks[PIDX_W'(ntok)] = mk_tok(KIND_LBRACK, SUB_NONE, depth_d, '0, '0,
                                           ST_OK, 1'b0);
              ntok  = ntok + 2'd1;
              any_d = 1'b1;
            end
          end
          CH_RPAREN: begin
            if (depth_q == '0) begin
              err_d = ST_BRACKET;
            end else begin
              if (nlen_q != '0) begin
                toks[PIDX_W'(ntok)] = mk_tok(KIND_NAME, SUB_NONE, '0, nstart_q, nlen_q,
                                             ST_OK, 1'b0);
                ntok   = ntok + 2'd1;
                nlen_d = '0;
              end
              toks[PIDX_W'(ntok)] = mk_tok(KIND_RBRACK, SUB_NONE, depth_q, '0, '0,
                                           ST_OK, 1'b0);
              ntok    = ntok + 2'd1;
              any_d   = 1'b1;
              depth_d = depth_q - 8'd1;
            end
          end
          CH_COMMA: begin
            if (depth_q == '0) begin
              err_d = ST_COMMA;
            end else if (last_i) begin
              err_d = ST_UNEXP_END;
            end else begin
              if (nlen_q != '0) begin
                toks[PIDX_W'(ntok)] = mk_tok(KIND_NAME, SUB_NONE, '0, nstart_q, nlen_q,
                                             ST_OK, 1'b0);
                ntok   = ntok + 2'd1;
                any_d  = 1'b1;
                nlen_d = '0;
              end
              held_d = HELD_COMMA;
              full_d = 1'b1;
            end
          end
          default: begin
            if (code != HELD_NONE) begin
              if (nlen_q != '0) begin
                toks[PIDX_W'(ntok)] = mk_tok(KIND_NAME, SUB_NONE, '0, nstart_q, nlen_q,
                                             ST_OK, 1'b0);
                ntok   = ntok + 2'd1;
                any_d  = 1'b1;
                nlen_d = '0;
              end
              held_d = code;
              full_d = 1'b0;
            end else begin
              if (nlen_q == '0) begin
                nstart_d = pos_q;
              end
              if (nlen_q != LEN_SAT) begin
                nlen_d = nlen_q + 16'd1;
              end
            end
          end
        endcase
      end
    end

    // end of expression: close out and return to the reset state
    if (last_i) begin
      if (err_d == ST_OK) begin
        if (held_d != HELD_NONE) begin
          err_d = (!full_d && ((held_d == HELD_AMP) || (held_d == HELD_BAR))) ?
                  ST_UNKNOWN : ST_UNEXP_END;
        end else begin
          if (nlen_d != '0) begin
            toks[PIDX_W'(ntok)] = mk_tok(KIND_NAME, SUB_NONE, '0, nstart_d, nlen_d,
                                         ST_OK, 1'b0);
            ntok  = ntok + 2'd1;
            any_d = 1'b1;
          end
          if (depth_d != '0) begin
            err_d = ST_BRACKET;
          end else if (!any_d) begin
            err_d = ST_EMPTY;
          end
        end
      end
      toks[PIDX_W'(ntok)] = mk_tok(KIND_END, SUB_NONE, '0, '0, '0, err_d, 1'b1);
      ntok     = ntok + 2'd1;
      depth_d  = '0;
      held_d   = HELD_NONE;
      full_d   = 1'b0;
      pos_d    = '0;
      nstart_d = '0;
      nlen_d   = '0;
      any_d    = 1'b0;
      err_d    = ST_OK;
    end
  end

  // state registers, advanced once per character beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= '0;
      held_q   <= HELD_NONE;
      full_q   <= 1'b0;
      pos_q    <= '0;
      nstart_q <= '0;
      nlen_q   <= '0;
      any_q    <= 1'b0;
      err_q    <= ST_OK;
    end else if (beat_i) begin
      depth_q  <= depth_d;
      held_q   <= held_d;
      full_q   <= full_d;
      pos_q    <= pos_d;
      nstart_q <= nstart_d;
      nlen_q   <= nlen_d;
      any_q    <= any_d;
      err_q    <= err_d;
    end
  end

  assign push_o.cnt = beat_i ? ntok : '0;
  assign push_o.tok = toks;

endmodule

// File: rtl/ect_fifo.sv
// ----------------------------------------------------------------------------
// Expression character tokenizer result queue
// Takes up to three tokens a cycle and hands out one token beat a cycle while the sink is ready.
// ----------------------------------------------------------------------------
module ect_fifo import ect_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ect_push_t         push_i,
  output logic [QCNT_W-1:0] space_o,
  ect_out_if.source         out_o
);

  tok_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;
  tok_t              head;

  assign pop   = out_o.valid && out_o.ready;
  assign cnt_d = cnt_q + QCNT_W'(push_i.cnt) - QCNT_W'(pop);

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
      cnt_q    <= cnt_d;
    end
  end

  // token storage, slot i lands i places after the write pointer
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PUSH_MAX; i++) begin
      if (PCNT_W'(i) < push_i.cnt) begin
        mem_q[wr_ptr_q + QPTR_W'(i)] <= push_i.tok[PIDX_W'(i)];
      end
    end
  end

  assign space_o = QCNT_W'(QDEPTH) - cnt_q;

  // head of queue drives the output beat
  assign head             = mem_q[rd_ptr_q];
  assign out_o.valid      = (cnt_q != '0);
  assign out_o.kind       = head.kind;
  assign out_o.sub        = head.sub;
  assign out_o.nest_depth = head.nest_depth;
  assign out_o.span_start = head.span_start;
  assign out_o.span_len   = head.span_len;
  assign out_o.status     = head.status;
  assign out_o.final_res  = head.final_res;

endmodule

// File: rtl/expression_char_tokenizer.sv
// ----------------------------------------------------------------------------
// Expression character tokenizer
// Turns a stream of expression characters, one per beat, into tokens:
// names as start and length, brackets with depth, commas, logic, comparison,
// arithmetic and assignment operators, and a closing end token with status.
// A character beat is taken every cycle while the result queue has room for
// three tokens; the character is registered, decided by combinational logic
// and its tokens (zero to three) are written to an eight-entry queue. Token
// beats leave at one per cycle while the sink is ready, so the output port
// sets the sustained rate whenever the text averages more than one token
// per character. An accepted character passes through the input register
// and the queue before its first token beat.
// ----------------------------------------------------------------------------
`include "expression_char_tokenizer_macros.svh"

module expression_char_tokenizer import ect_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ect_in_if.sink    in_i,
  ect_out_if.source out_o
);

  logic              in_vld_q;
  logic [CH_W-1:0]   ch_q;
  logic              last_q;
  logic              advance;
  logic [QCNT_W-1:0] space;
  ect_push_t         push;

  // input register advances when the queue can take a worst-case burst
  assign advance    = in_vld_q && (space >= QCNT_W'(PUSH_MAX));
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q   <= in_i.ch;
      last_q <= in_i.last;
    end
  end

  // token decision
  ect_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (advance),
    .ch_i   (ch_q),
    .last_i (last_q),
    .push_o (push)
  );

  // result queue
  ect_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .out_o   (out_o)
  );

  // checks
  `ECT_ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, push.cnt <= space, "queue overflow")
  `ECT_ASSERT_IMPLIES(a_end_last, clk_i, rst_ni, advance && last_q, (push.cnt != '0) && push.tok[PIDX_W'(push.cnt - 2'd1)].final_res, "end token missing")
  `ECT_ASSERT_IMPLIES(a_stall_held, clk_i, rst_ni, !in_i.ready, in_vld_q && !advance, "stall without held beat")

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Expression character tokenizer testbench
// Feeds character beats with random gaps and output stalls, including one
// long hold-off on the token side, predicts every token with a software
// scanner kept in step with the accepted characters and compares each token
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import ect_pkg::*;

  localparam int unsigned RANDOM_CHARS    = 170;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 120;
  localparam int unsigned HOLD_OFF_AFTER  = 40;
  localparam int unsigned DRAIN_CYCLES    = 12;

  localparam logic [CH_W-1:0] CH_MIN     = 8'h00;
  localparam logic [CH_W-1:0] CH_MAX     = 8'hFF;
  localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CH_W-1:0] CH_DIGIT_0 = 8'h30;

  typedef struct {
    logic [CH_W-1:0] ch;
    logic            last;
    int unsigned     gap;
  } char_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  ect_in_if  in_if ();
  ect_out_if out_if ();

  expression_char_tokenizer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // clock
  always #6 clk = ~clk;

  // stimulus and expected token stores
  char_beat_t      pending_chars[$];
  logic [CH_W-1:0] text_buf[$];
  tok_t            expected_tokens[$];

  string binary_ops[15] = '{">", ">=", "<", "<=", "==", "!=", "+", "-", "*", "=",
                            "+=", "-=", "*=", "&&", "||"};
  logic [CH_W-1:0] trouble_bytes[6] = '{CH_LPAREN, CH_RPAREN, CH_COMMA, CH_AMP,
                                        CH_BAR, CH_EQ};

  int unsigned chars_total;
  int unsigned chars_taken;
  int unsigned exprs_total;
  int unsigned tokens_checked;
  int unsigned mismatches;
  int unsigned status_seen[8];
  int unsigned quiet_cycles;
  int unsigned gap_count;
  int unsigned stall_left;
  bit          char_taken;
  bit          hold_off;

  // scanner state
  logic [NEST_W-1:0] scan_depth;
  logic [HELD_W-1:0] scan_held;
  logic              scan_paired;
  logic [POS_W-1:0]  scan_pos;
  logic [POS_W-1:0]  scan_name_start;
  logic [POS_W-1:0]  scan_name_len;
  logic              scan_any_token;
  logic [STAT_W-1:0] scan_error;

  function automatic void scanner_clear();
    scan_depth      = '0;
    scan_held       = HELD_NONE;
    scan_paired     = 1'b0;
    scan_pos        = '0;
    scan_name_start = '0;
    scan_name_len   = '0;
    scan_any_token  = 1'b0;
    scan_error      = ST_OK;
  endfunction

  function automatic bit is_blank(logic [CH_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic [HELD_W-1:0] operator_code(logic [CH_W-1:0] c);
    case (c)
      CH_GT:    return HELD_GT;
      CH_LT:    return HELD_LT;
      CH_BANG:  return HELD_BANG;
      CH_PLUS:  return HELD_PLUS;
      CH_MINUS: return HELD_MINUS;
      CH_STAR:  return HELD_STAR;
      CH_EQ:    return HELD_EQ;
      CH_AMP:   return HELD_AMP;
      CH_BAR:   return HELD_BAR;
      default:  return HELD_NONE;
    endcase
  endfunction

  // meaning of a held operator, alone or with its follower
  function automatic void held_meaning(input logic [HELD_W-1:0] h, input logic paired,
                                       output logic [KIND_W-1:0] kind,
                                       output logic [SUB_W-1:0] sub);
    kind = KIND_NAME;
    sub  = SUB_NONE;
    if (paired) begin
      case (h)
        HELD_GT:    begin kind = KIND_CMP;    sub = CMP_GE;  end
        HELD_LT:    begin kind = KIND_CMP;    sub = CMP_LE;  end
        HELD_BANG:  begin kind = KIND_CMP;    sub = CMP_NE;  end
        HELD_PLUS:  begin kind = KIND_ASSIGN; sub = ASG_ADD; end
        HELD_MINUS: begin kind = KIND_ASSIGN; sub = ASG_SUB; end
        HELD_STAR:  begin kind = KIND_ASSIGN; sub = ASG_MUL; end
        HELD_EQ:    begin kind = KIND_CMP;    sub = CMP_EQ;  end
        HELD_AMP:   kind = KIND_AND;
        HELD_BAR:   kind = KIND_OR;
        HELD_COMMA: kind = KIND_COMMA;
        default:    kind = KIND_NAME;
      endcase
    end else begin
      case (h)
        HELD_GT:    begin kind = KIND_CMP;    sub = CMP_GT;  end
        HELD_LT:    begin kind = KIND_CMP;    sub = CMP_LT;  end
        HELD_BANG:  begin kind = KIND_OP;     sub = OP_NOT;  end
        HELD_PLUS:  begin kind = KIND_OP;     sub = OP_ADD;  end
        HELD_MINUS: begin kind = KIND_OP;     sub = OP_SUB;  end
        HELD_STAR:  begin kind = KIND_OP;     sub = OP_MUL;  end
        HELD_EQ:    begin kind = KIND_ASSIGN; sub = ASG_SET; end
        default:    kind = KIND_NAME;
      endcase
    end
  endfunction

  function automatic void push_token(logic [KIND_W-1:0] kind, logic [SUB_W-1:0] sub,
                                     logic [NEST_W-1:0] nd, logic [POS_W-1:0] ss,
                                     logic [POS_W-1:0] sl, logic [STAT_W-1:0] st,
                                     logic fin);
    tok_t t;
    t.kind       = kind;
    t.sub        = sub;
    t.nest_depth = nd;
    t.span_start = ss;
    t.span_len   = sl;
    t.status     = st;
    t.final_res  = fin;
    expected_tokens.insert(expected_tokens.size(), t);
    if (kind != KIND_END) scan_any_token = 1'b1;
  endfunction

  function automatic void flush_name();
    if (scan_name_len != '0) begin
      push_token(KIND_NAME, SUB_NONE, '0, scan_name_start, scan_name_len, ST_OK, 1'b0);
      scan_name_len = '0;
    end
  endfunction

  // one non-blank character while no error is pending
  function automatic void scan_char(logic [CH_W-1:0] c, logic last);
    logic [POS_W-1:0]  here;
    logic [HELD_W-1:0] code;
    logic [KIND_W-1:0] kind;
    logic [SUB_W-1:0]  sub;
    here     = scan_pos;
    scan_pos = scan_pos + 1'b1;

    // resolve a held operator first
    if (scan_held != HELD_NONE) begin
      if (scan_paired) begin
        held_meaning(scan_held, 1'b1, kind, sub);
        push_token(kind, sub, (scan_held == HELD_COMMA) ? scan_depth : '0,
                   '0, '0, ST_OK, 1'b0);
        scan_held   = HELD_NONE;
        scan_paired = 1'b0;
      end else if (scan_held == HELD_AMP || scan_held == HELD_BAR) begin
        if (c == ((scan_held == HELD_AMP) ? CH_AMP : CH_BAR)) scan_paired = 1'b1;
        else scan_error = ST_UNKNOWN;
        return;
      end else if (c == CH_EQ) begin
        scan_paired = 1'b1;
        return;
      end else begin
        held_meaning(scan_held, 1'b0, kind, sub);
        push_token(kind, sub, '0, '0, '0, ST_OK, 1'b0);
        scan_held = HELD_NONE;
      end
    end

    if (c == CH_LPAREN) begin
      if (last) begin
        scan_error = ST_BRACKET;
        return;
      end
      if (scan_depth >= NEST_LIMIT) begin
        scan_error = ST_OVERFLOW;
        return;
      end
      flush_name();
      scan_depth = scan_depth + 1'b1;
      push_token(KIND_LBRACK, SUB_NONE, scan_depth, '0, '0, ST_OK, 1'b0);
    end else if (c == CH_RPAREN) begin
      if (scan_depth == '0) begin
        scan_error = ST_BRACKET;
        return;
      end
      flush_name();
      push_token(KIND_RBRACK, SUB_NONE, scan_depth, '0, '0, ST_OK, 1'b0);
      scan_depth = scan_depth - 1'b1;
    end else if (c == CH_COMMA) begin
      if (scan_depth == '0) begin
        scan_error = ST_COMMA;
        return;
      end
      if (last) begin
        scan_error = ST_UNEXP_END;
        return;
      end
      flush_name();
      scan_held   = HELD_COMMA;
      scan_paired = 1'b1;
    end else begin
      code = operator_code(c);
      if (code != HELD_NONE) begin
        flush_name();
        scan_held   = code;
        scan_paired = 1'b0;
      end else begin
        if (scan_name_len == '0) scan_name_start = here;
        if (scan_name_len != LEN_SAT) scan_name_len = scan_name_len + 1'b1;
      end
    end
  endfunction

  // tokens caused by one accepted character beat
  function automatic void predict_tokens(logic [CH_W-1:0] c, logic last);
    if (!is_blank(c) && scan_error == ST_OK) scan_char(c, last);
    if (last) begin
      if (scan_error == ST_OK) begin
        if (scan_held != HELD_NONE) begin
          scan_error = (!scan_paired && (scan_held == HELD_AMP || scan_held == HELD_BAR)) ?
                       ST_UNKNOWN : ST_UNEXP_END;
        end else begin
          flush_name();
          if (scan_depth != '0) scan_error = ST_BRACKET;
          else if (!scan_any_token) scan_error = ST_EMPTY;
        end
      end
      push_token(KIND_END, SUB_NONE, '0, '0, '0, scan_error, 1'b1);
      scanner_clear();
    end
  endfunction

  function automatic void compare_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: token %0d %s expected %0h actual %0h",
               $time, tokens_checked, fname, want, got);
      mismatches++;
    end
  endfunction

  // text generation
  function automatic logic [CH_W-1:0] blank_byte();
    if ($urandom_range(0, 1) == 0) return CH_SPACE;
    return CH_W'(CH_TAB + $urandom_range(0, 4));
  endfunction

  function automatic logic [CH_W-1:0] name_byte();
    logic [CH_W-1:0] b;
    int unsigned     r;
    r = $urandom_range(0, 9);
    if (r < 6) return CH_W'(CH_LOWER_A + $urandom_range(0, 25));
    if (r < 8) return CH_W'(CH_DIGIT_0 + $urandom_range(0, 9));
    do begin
      b = CH_W'($urandom_range(0, 255));
    end while (is_blank(b) || operator_code(b) != HELD_NONE || b == CH_LPAREN ||
               b == CH_RPAREN || b == CH_COMMA);
    return b;
  endfunction

  // append one byte to the text buffer
  task automatic add_text_byte(logic [CH_W-1:0] b);
    text_buf.insert(text_buf.size(), b);
  endtask

  // byte with an occasional blank in front
  task automatic put_byte(logic [CH_W-1:0] b);
    if ($urandom_range(0, 5) == 0) add_text_byte(blank_byte());
    add_text_byte(b);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic gen_operand(int unsigned lvl);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) put_byte(CH_BANG);
    else if (r == 1) put_byte(CH_MINUS);
    if (lvl < 3 && $urandom_range(0, 3) == 0) begin
      put_byte(CH_LPAREN);
      gen_expr(lvl + 1);
      while ($urandom_range(0, 2) == 0) begin
        put_byte(CH_COMMA);
        gen_expr(lvl + 1);
      end
      put_byte(CH_RPAREN);
    end else begin
      repeat ($urandom_range(1, 4)) put_byte(name_byte());
    end
  endtask

  task automatic gen_expr(int unsigned lvl);
    gen_operand(lvl);
    repeat ($urandom_range(0, 2)) begin
      put_text(binary_ops[$urandom_range(0, 14)]);
      gen_operand(lvl);
    end
  endtask

  // move the text buffer into the beat queue, last flag on its final byte
  task automatic queue_expression(int unsigned gap_max);
    char_beat_t beat;
    for (int i = 0; i < text_buf.size(); i++) begin
      beat.ch   = text_buf[i];
      beat.last = (i == text_buf.size() - 1);
      beat.gap  = $urandom_range(0, gap_max);
      pending_chars.insert(pending_chars.size(), beat);
    end
    chars_total += text_buf.size();
    exprs_total++;
    text_buf.delete();
  endtask

  task automatic directed_text(string s);
    for (int i = 0; i < s.len(); i++) add_text_byte(s[i]);
    queue_expression(9);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned cut;
    int unsigned random_chars;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.ch     = CH_MIN;
    in_if.last   = 1'b0;
    out_if.ready = 1'b0;
    random_chars = 0;
    scanner_clear();

    // directed: extreme bytes as one name, then the error cases
    add_text_byte(CH_MIN);
    add_text_byte(CH_MAX);
    queue_expression(9);
    directed_text(" ");
    directed_text("a&b");
    directed_text("a|");
    directed_text("(");
    directed_text(")x");
    directed_text("a+");
    directed_text("(a,");
    directed_text("a,b");
    directed_text("((a)");

    // random: mostly well-formed text, some broken, some noise
    while (random_chars < RANDOM_CHARS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        gen_expr(0);
        if (pick >= 70) begin
          cut = $urandom_range(0, text_buf.size() - 1);
          case ($urandom_range(0, 2))
            0:       text_buf[cut] = trouble_bytes[$urandom_range(0, 5)];
            1:       text_buf[cut] = CH_W'($urandom_range(0, 255));
            default: while (text_buf.size() > cut + 1) text_buf.delete(text_buf.size() - 1);
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 6)) add_text_byte(CH_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 4) == 0) add_text_byte(blank_byte());
      random_chars += text_buf.size();
      queue_expression((exprs_total % 4 == 3) ? 0 : 9);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (chars_taken != chars_total || expected_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Summary: %0d expressions, %0d characters, %0d tokens checked, %0d mismatches",
             exprs_total, chars_taken, tokens_checked, mismatches);
    $display("End statuses: ok %0d empty %0d bracket %0d unknown %0d early end %0d",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_BRACKET],
             status_seen[ST_UNKNOWN], status_seen[ST_UNEXP_END]);
    $display("End statuses: comma %0d overflow %0d",
             status_seen[ST_COMMA], status_seen[ST_OVERFLOW]);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // long hold-off on the token side so the block backs up
  initial begin : token_hold_off
    hold_off = 1'b0;
    wait (tokens_checked >= HOLD_OFF_AFTER);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // character beat driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || char_taken) begin
      char_taken = 1'b0;
      if (pending_chars.size() != 0 && gap_count >= pending_chars[0].gap) begin
        in_if.ch    <= pending_chars[0].ch;
        in_if.last  <= pending_chars[0].last;
        in_if.valid <= 1'b1;
        void'(pending_chars.pop_front());
        gap_count = 0;
      end else begin
        in_if.valid <= 1'b0;
        if (pending_chars.size() != 0) gap_count++;
      end
    end
  end

  // token sink ready with random stalls
  always @(negedge clk) begin
    if (!rst_n || hold_off || stall_left != 0) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
    if (rst_n && !hold_off && stall_left != 0) stall_left--;
  end

  // accepted beats: predict on the input side, check on the output side
  always @(posedge clk) begin : beat_monitor
    tok_t want;
    bit   beat_seen;
    if (rst_n) begin
      beat_seen = 1'b0;
      if (in_if.valid && in_if.ready) begin
        predict_tokens(in_if.ch, in_if.last);
        chars_taken++;
        char_taken = 1'b1;
        beat_seen  = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        beat_seen = 1'b1;
        if (expected_tokens.size() == 0) begin
          $display("%0t: token %0d expected none actual kind %0h status %0h",
                   $time, tokens_checked, out_if.kind, out_if.status);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          compare_field("kind", 32'(want.kind), 32'(out_if.kind));
          compare_field("sub", 32'(want.sub), 32'(out_if.sub));
          compare_field("nest_depth", 32'(want.nest_depth), 32'(out_if.nest_depth));
          compare_field("span_start", 32'(want.span_start), 32'(out_if.span_start));
          compare_field("span_len", 32'(want.span_len), 32'(out_if.span_len));
          compare_field("status", 32'(want.status), 32'(out_if.status));
          compare_field("final_res", 32'(want.final_res), 32'(out_if.final_res));
          if (want.final_res) status_seen[want.status]++;
        end
        tokens_checked++;
        // calm stretches with no stalls every third block of fifty tokens
        stall_left = (((tokens_checked / 50) % 3) == 2) ? 0 : $urandom_range(0, 9);
      end

      // watchdog on beats of either side
      if (beat_seen) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

// File: expression_char_tokenizer.f
+incdir+rtl
rtl/ect_pkg.sv
rtl/ect_if.sv
rtl/ect_core.sv
rtl/ect_fifo.sv
rtl/expression_char_tokenizer.sv
test/testbench.sv
